[sv/sks_pkg.sv]
// Shared constants and types for the sorted key table search block
`default_nettype none

package sks_pkg;

	// Default table geometry
	localparam int ENTRIES_DEF   = 256;
	localparam int KEY_WORDS_DEF = 32;

	// Fixed field widths
	localparam int CMD_W   = 2;
	localparam int ENT_W   = 8;
	localparam int WIDX_W  = 5;
	localparam int DATA_W  = 64;
	localparam int COUNT_W = 9;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_TBL  = 2'd0,
		CMD_QRY  = 2'd1,
		CMD_SRCH = 2'd2
	} sks_cmd_t;

	// Key store control from the search engine
	typedef struct packed {
		logic tbl_we;
		logic qry_we;
		logic rd_en;
	} sks_mem_ctl_t;

endpackage

`default_nettype wire

[sv/sks_key_store.sv]
// Key table and query key memories, one write and one registered read each
`default_nettype none

module sks_key_store import sks_pkg::*; #(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int KEY_WORDS = KEY_WORDS_DEF,
	localparam int TAW = (ENTRIES * KEY_WORDS > 1) ? $clog2(ENTRIES * KEY_WORDS) : 1,
	localparam int WW  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1
) (
	input  wire logic              clk,
	input  wire sks_mem_ctl_t      ctl,
	input  wire logic [TAW-1:0]    t_waddr,
	input  wire logic [WW-1:0]     q_waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [TAW-1:0]    t_raddr,
	input  wire logic [WW-1:0]     q_raddr,
	output logic      [DATA_W-1:0] t_rdata,
	output logic      [DATA_W-1:0] q_rdata
);

	logic [DATA_W-1:0] tbl_mem [ENTRIES*KEY_WORDS];
	logic [DATA_W-1:0] qry_mem [KEY_WORDS];
	logic [DATA_W-1:0] t_rd_q;
	logic [DATA_W-1:0] q_rd_q;

	// Table memory: write on load, registered read on probe
	always_ff @(posedge clk) begin
		if (ctl.tbl_we) begin
			tbl_mem[t_waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			t_rd_q <= tbl_mem[t_raddr];
		end
	end

	// Query memory: same shape, one word per key position
	always_ff @(posedge clk) begin
		if (ctl.qry_we) begin
			qry_mem[q_waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			q_rd_q <= qry_mem[q_raddr];
		end
	end

	assign t_rdata = t_rd_q;
	assign q_rdata = q_rd_q;

endmodule

`default_nettype wire

[sv/sorted_key_table_search_core.sv]
// Sorted key table with lower-bound binary search over stored string keys
//
//  channel   | direction | handshake            | word contents
//  ----------+-----------+----------------------+------------------------------------
//  in        | input     | in_valid / in_ready  | cmd, entry_index, word_index, word_data
//  out       | output    | out_valid / out_ready| found
//  config    | input     | entry_count_we       | entry_count
//
//  A load is written to memory as it is accepted. A search runs a series of probes;
//  a probe ends early at the first differing word.
//  Each probe streams key words through the registered memory read port.
//  One command is worked on at a time; in_ready is low during a search.
//  A finished answer waits in the output register; loads continue meanwhile.
//  Reset clears control state and entry_count; memory contents are undefined until loaded.
`default_nettype none

module sorted_key_table_search_core import sks_pkg::*; #(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int KEY_WORDS = KEY_WORDS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [CMD_W-1:0]   cmd,
	input  wire logic [ENT_W-1:0]   entry_index,
	input  wire logic [WIDX_W-1:0]  word_index,
	input  wire logic [DATA_W-1:0]  word_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    found,
	input  wire logic               entry_count_we,
	input  wire logic [COUNT_W-1:0] entry_count
);

	localparam int TAW = (ENTRIES * KEY_WORDS > 1) ? $clog2(ENTRIES * KEY_WORDS) : 1;
	localparam int WW  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam int WCW = $clog2(KEY_WORDS + 1);
	localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PRB,
		S_CMP,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] count_q;
	logic [EW-1:0]      lo_q;
	logic [EW-1:0]      hi_q;
	logic [EW-1:0]      mid_q;
	logic               final_q;
	logic [TAW-1:0]     base_q;
	logic [WCW-1:0]     w_q;
	logic               chk_vld_s1;
	logic               chk_last_s1;
	logic               res_q;
	logic               out_valid_q;
	logic               found_q;

	sks_mem_ctl_t       mem_ctl;
	logic [TAW-1:0]     t_waddr;
	logic [TAW-1:0]     t_raddr;
	logic [DATA_W-1:0]  t_rdata;
	logic [DATA_W-1:0]  q_rdata;

	logic               acc;
	logic               tbl_ok;
	logic               qry_ok;
	logic [EW:0]        mid_sum;
	logic [EW-1:0]      mid_nxt;
	logic [EW-1:0]      hi_init;
	logic               cmp_done;
	logic               issue;
	logic               out_load;

	// Input side: a word is taken only when idle
	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	// Range checks for loads
	assign tbl_ok = (32'(entry_index) < ENTRIES) && (32'(word_index) < KEY_WORDS);
	assign qry_ok = (32'(word_index) < KEY_WORDS);

	// Memory write and read addresses
	assign t_waddr = TAW'(32'(entry_index) * KEY_WORDS + 32'(word_index));
	assign t_raddr = base_q + TAW'(w_q);

	// Search bounds: count clamped to the table size
	assign hi_init = (32'(count_q) > ENTRIES) ? EW'(ENTRIES - 1) : EW'(32'(count_q) - 32'd1);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_nxt = mid_sum[EW:1];

	// Word compare: stop at the first difference or after the last word
	assign cmp_done = chk_vld_s1 && ((q_rdata != t_rdata) || chk_last_s1);
	assign issue    = (state_q == S_CMP) && !cmp_done && (w_q < WCW'(KEY_WORDS));

	assign mem_ctl.tbl_we = acc && (cmd == CMD_TBL) && tbl_ok;
	assign mem_ctl.qry_we = acc && (cmd == CMD_QRY) && qry_ok;
	assign mem_ctl.rd_en  = issue;

	// Output register is free when empty or being drained
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	sks_key_store #(
		.ENTRIES   (ENTRIES),
		.KEY_WORDS (KEY_WORDS)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.t_waddr (t_waddr),
		.q_waddr (WW'(word_index)),
		.wdata   (word_data),
		.t_raddr (t_raddr),
		.q_raddr (w_q[WW-1:0]),
		.t_rdata (t_rdata),
		.q_rdata (q_rdata)
	);

	// Sequencer: probe setup, word compare, bound update, answer hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			final_q     <= 1'b0;
			base_q      <= '0;
			w_q         <= '0;
			chk_vld_s1  <= 1'b0;
			chk_last_s1 <= 1'b0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (entry_count_we) begin
				count_q <= entry_count;
			end

			// Hold the answer until taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				found_q     <= res_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (acc && (cmd == CMD_SRCH)) begin
						lo_q    <= '0;
						hi_q    <= hi_init;
						final_q <= 1'b0;
						res_q   <= 1'b0;
						if (count_q == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_PRB;
						end
					end
				end
				S_PRB: begin
					// Pick the probe entry and its row base
					if (lo_q < hi_q) begin
						mid_q  <= mid_nxt;
						base_q <= TAW'(32'(mid_nxt) * KEY_WORDS);
					end else begin
						final_q <= 1'b1;
						base_q  <= TAW'(32'(lo_q) * KEY_WORDS);
					end
					w_q         <= '0;
					chk_vld_s1  <= 1'b0;
					chk_last_s1 <= 1'b0;
					state_q     <= S_CMP;
				end
				S_CMP: begin
					// issue is low once the compare is done, which drops the stage
					chk_vld_s1  <= issue;
					chk_last_s1 <= (w_q == WCW'(KEY_WORDS - 1));
					if (issue) begin
						w_q <= w_q + WCW'(1);
					end
					if (cmp_done) begin
						if (final_q) begin
							res_q   <= (q_rdata == t_rdata);
							state_q <= S_DONE;
						end else begin
							// Advance the bounds
							if (q_rdata > t_rdata) begin
								lo_q <= mid_q + EW'(1);
							end else begin
								hi_q <= mid_q;
							end
							state_q <= S_PRB;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;

	// A compare stage only follows a compare cycle
	a_chk_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> $past(state_q == S_CMP))
		else $error("compare stage valid outside a probe");

	// Search bounds never cross during a probe
	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	// Table reads stay inside the table
	a_raddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (32'(t_raddr) < ENTRIES * KEY_WORDS))
		else $error("table read address out of range");

	// A stalled answer keeps the search parked
	a_done_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && out_valid_q && !out_ready) |=> (state_q == S_DONE))
		else $error("answer overwritten while output stalled");

	// No memory write while a search is running
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctl.tbl_we || mem_ctl.qry_we) |-> (state_q == S_IDLE))
		else $error("key store written during a search");

endmodule

`default_nettype wire
